>>> design/erpm_pkg.sv
// erpm_pkg: shared types, register codes and widths for the ellipse ring marker.
// No dependencies; imported by every design file but erpm_checker.
`default_nettype none
package erpm_pkg;

    localparam int MAX_SIDE   = 4096;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int COORD_W    = 12;
    localparam int PIX_W      = 24;
    localparam int Q_W        = 16;
    localparam int HW_W       = 6;
    localparam int SQ_W       = 32;   // 16 x 16 squares
    localparam int P2_W       = 64;   // (w*h)^2
    localparam int T2_W       = 52;   // 256*hw^2*w*h
    localparam int U_W        = 65;   // P^2 + T2
    localparam int K_W        = 118;  // 4*P^2*T2
    localparam int S_W        = 67;   // 4*(X^2 H^2 + Y^2 W^2)
    localparam int DSQ_W      = 134;  // (S-U)^2

    typedef enum logic [2:0] {
        REG_CENTRE_COL  = 3'd0,
        REG_CENTRE_ROW  = 3'd1,
        REG_BOX_WIDTH   = 3'd2,
        REG_BOX_HEIGHT  = 3'd3,
        REG_HALF_WIDTH  = 3'd4,
        REG_RING_COLOUR = 3'd5
    } t_reg_idx;

    localparam logic [HW_W-1:0] HALF_WIDTH_RST = HW_W'(6);

    typedef struct packed {
        logic [Q_W-1:0]   centre_col;
        logic [Q_W-1:0]   centre_row;
        logic [Q_W-1:0]   box_width;
        logic [Q_W-1:0]   box_height;
        logic [HW_W-1:0]  ring_half_width;
        logic [PIX_W-1:0] ring_colour;
    } t_cfg;

    // Values that follow from configuration alone.
    typedef struct packed {
        logic [SQ_W-1:0] w2;
        logic [SQ_W-1:0] h2;
        logic [U_W-1:0]  u;
        logic [K_W-1:0]  k;
        logic            p2_lt_t2;
        logic            mark_en;
    } t_derived;

endpackage
`default_nettype wire

>>> design/erpm_apb_regs.sv
// erpm_apb_regs: APB register file holding the ellipse geometry and ring colour.
// Depends on erpm_pkg.
`default_nettype none
module erpm_apb_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [erpm_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [erpm_pkg::DATA_W-1:0]  pwdata,
    output logic      [erpm_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    output erpm_pkg::t_cfg                    o_cfg
);
    import erpm_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.centre_col      <= '0;
            r_cfg.centre_row      <= '0;
            r_cfg.box_width       <= '0;
            r_cfg.box_height      <= '0;
            r_cfg.ring_half_width <= HALF_WIDTH_RST;
            r_cfg.ring_colour     <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_CENTRE_COL:  r_cfg.centre_col      <= pwdata[Q_W-1:0];
                REG_CENTRE_ROW:  r_cfg.centre_row      <= pwdata[Q_W-1:0];
                REG_BOX_WIDTH:   r_cfg.box_width       <= pwdata[Q_W-1:0];
                REG_BOX_HEIGHT:  r_cfg.box_height      <= pwdata[Q_W-1:0];
                REG_HALF_WIDTH:  r_cfg.ring_half_width <= pwdata[HW_W-1:0];
                REG_RING_COLOUR: r_cfg.ring_colour     <= pwdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_CENTRE_COL:  prdata = DATA_W'(r_cfg.centre_col);
            REG_CENTRE_ROW:  prdata = DATA_W'(r_cfg.centre_row);
            REG_BOX_WIDTH:   prdata = DATA_W'(r_cfg.box_width);
            REG_BOX_HEIGHT:  prdata = DATA_W'(r_cfg.box_height);
            REG_HALF_WIDTH:  prdata = DATA_W'(r_cfg.ring_half_width);
            REG_RING_COLOUR: prdata = DATA_W'(r_cfg.ring_colour);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

>>> design/erpm_cfg_derive.sv
// erpm_cfg_derive: free-running chain that turns the box sizes and half width
// into the squared bounds of the ring test. Depends on erpm_pkg.
`default_nettype none
module erpm_cfg_derive (
    input  wire logic             i_clk,
    input  wire erpm_pkg::t_cfg   i_cfg,
    output erpm_pkg::t_derived    o_der
);
    import erpm_pkg::*;

    // stage 1
    logic [SQ_W-1:0] r_w2, r_h2, r_p;
    logic [19:0]     r_hs;     // 256*hw^2
    logic            r_en1;
    // stage 2
    logic [P2_W-1:0] r_p2;
    logic [T2_W-1:0] r_t2;
    logic            r_en2;
    // stage 3
    logic [U_W-1:0]  r_u;
    logic            r_lt;
    logic [63:0]     r_a0b0, r_a0b1, r_a1b0;
    logic [51:0]     r_a1b1;
    logic            r_en3;
    // stage 4
    t_derived        r_der;
    logic [K_W-3:0]  w_pt;

    always_ff @(posedge i_clk) begin
        r_w2  <= SQ_W'(i_cfg.box_width)  * SQ_W'(i_cfg.box_width);
        r_h2  <= SQ_W'(i_cfg.box_height) * SQ_W'(i_cfg.box_height);
        r_p   <= SQ_W'(i_cfg.box_width)  * SQ_W'(i_cfg.box_height);
        r_hs  <= {20'(i_cfg.ring_half_width) * 20'(i_cfg.ring_half_width)} << 8;
        r_en1 <= (i_cfg.box_width != '0) && (i_cfg.box_height != '0)
                 && (i_cfg.ring_half_width != '0);

        r_p2  <= P2_W'(r_p) * P2_W'(r_p);
        r_t2  <= T2_W'(r_hs) * T2_W'(r_p);
        r_en2 <= r_en1;

        r_u    <= U_W'(r_p2) + U_W'(r_t2);
        r_lt   <= P2_W'(r_t2) > r_p2;
        r_a0b0 <= 64'(r_p2[31:0])  * 64'(r_t2[31:0]);
        r_a0b1 <= 64'(r_p2[31:0])  * 64'(r_t2[51:32]);
        r_a1b0 <= 64'(r_p2[63:32]) * 64'(r_t2[31:0]);
        r_a1b1 <= 52'(r_p2[63:32]) * 52'(r_t2[51:32]);
        r_en3  <= r_en2;

        // axis squares skip ahead: the pixel pipe reads them early
        r_der.w2       <= r_w2;
        r_der.h2       <= r_h2;
        r_der.u        <= r_u;
        r_der.k        <= {w_pt, 2'b00};
        r_der.p2_lt_t2 <= r_lt;
        r_der.mark_en  <= r_en3;
    end

    assign w_pt = (K_W-2)'(r_a0b0)
                + ((K_W-2)'(r_a0b1) << 32)
                + ((K_W-2)'(r_a1b0) << 32)
                + ((K_W-2)'(r_a1b1) << 64);

    assign o_der = r_der;

endmodule
`default_nettype wire

>>> design/erpm_ring_pipe.sv
// erpm_ring_pipe: eight-stage pixel pipeline for the exact ring test, with a
// global advance so a stalled output holds every stage. Depends on erpm_pkg.
`default_nettype none
module erpm_ring_pipe (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire erpm_pkg::t_cfg                i_cfg,
    input  wire erpm_pkg::t_derived            i_der,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [erpm_pkg::COORD_W-1:0]  i_pixel_row,
    input  wire logic [erpm_pkg::COORD_W-1:0]  i_pixel_col,
    input  wire logic [erpm_pkg::PIX_W-1:0]    i_old_pixel,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [erpm_pkg::PIX_W-1:0]    o_new_pixel,
    output logic                               o_on_ring
);
    import erpm_pkg::*;

    localparam int NSTG = 8;

    logic [NSTG-1:0] r_v;
    logic            w_adv;
    logic [PIX_W-1:0] r_old [NSTG-1];
    logic [NSTG-2:0]  r_inr;

    logic [Q_W-1:0]   r_ax, r_ay;
    logic [SQ_W-1:0]  r_ax2, r_ay2;
    logic [63:0]      r_mx, r_my;
    logic [S_W-1:0]   r_s;
    logic [S_W-1:0]   r_d;
    logic             r_lt5, r_lt6, r_lt7;
    logic [63:0]      r_pp00, r_pp01, r_pp11;
    logic [S_W-1:0]   r_pp2;
    logic [5:0]       r_d2sq;
    logic [DSQ_W-1:0] r_dsq;
    logic [PIX_W-1:0] r_new;
    logic             r_hit;

    logic [Q_W-1:0]   w_px, w_py;
    logic [S_W-1:0]   w_u;

    assign w_adv   = !(r_v[NSTG-1] && i_stall);
    assign o_stall = !w_adv;

    assign w_px = {i_pixel_col, 4'b0000};
    assign w_py = {i_pixel_row, 4'b0000};
    assign w_u  = S_W'(i_der.u);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // S1: offsets from the centre
            r_ax     <= (w_px >= i_cfg.centre_col) ? w_px - i_cfg.centre_col
                                                    : i_cfg.centre_col - w_px;
            r_ay     <= (w_py >= i_cfg.centre_row) ? w_py - i_cfg.centre_row
                                                    : i_cfg.centre_row - w_py;
            r_inr[0] <= (13'(i_pixel_row) < 13'(MAX_SIDE))
                        && (13'(i_pixel_col) < 13'(MAX_SIDE));
            r_old[0] <= i_old_pixel;
            // S2: squares
            r_ax2 <= SQ_W'(r_ax) * SQ_W'(r_ax);
            r_ay2 <= SQ_W'(r_ay) * SQ_W'(r_ay);
            // S3: scale by the other axis
            r_mx <= 64'(r_ax2) * 64'(i_der.h2);
            r_my <= 64'(r_ay2) * 64'(i_der.w2);
            // S4: S
            r_s <= {(S_W-2)'(r_mx) + (S_W-2)'(r_my), 2'b00};
            // S5: distance from U
            r_lt5 <= r_s < w_u;
            r_d   <= (r_s < w_u) ? w_u - r_s : r_s - w_u;
            // S6: partial products of d^2
            r_pp00 <= 64'(r_d[31:0])  * 64'(r_d[31:0]);
            r_pp01 <= 64'(r_d[31:0])  * 64'(r_d[63:32]);
            r_pp11 <= 64'(r_d[63:32]) * 64'(r_d[63:32]);
            r_pp2  <= S_W'(r_d[66:64]) * S_W'(r_d[63:0]);
            r_d2sq <= 6'(r_d[66:64]) * 6'(r_d[66:64]);
            r_lt6  <= r_lt5;
            // S7: sum d^2
            r_dsq <= DSQ_W'(r_pp00)
                   + (DSQ_W'(r_pp01) << 33)
                   + (DSQ_W'(r_pp11) << 64)
                   + (DSQ_W'(r_pp2)  << 65)
                   + (DSQ_W'(r_d2sq) << 128);
            r_lt7 <= r_lt6;
            // S8: decide and mux the colour
            r_hit <= i_der.mark_en && r_inr[NSTG-2]
                     && ((r_lt7 && i_der.p2_lt_t2) || (r_dsq < DSQ_W'(i_der.k)));
            r_new <= (i_der.mark_en && r_inr[NSTG-2]
                      && ((r_lt7 && i_der.p2_lt_t2) || (r_dsq < DSQ_W'(i_der.k))))
                     ? i_cfg.ring_colour : r_old[NSTG-2];
            for (int i = 1; i < NSTG-1; i++) begin
                r_old[i] <= r_old[i-1];
                r_inr[i] <= r_inr[i-1];
            end
        end
    end

    assign o_valid     = r_v[NSTG-1];
    assign o_new_pixel = r_new;
    assign o_on_ring   = r_hit;

endmodule
`default_nettype wire

>>> design/ellipse_ring_pixel_marker_core.sv
// ellipse_ring_pixel_marker_core: top level of the ellipse ring overlay.
// Depends on erpm_pkg, erpm_apb_regs, erpm_cfg_derive and erpm_ring_pipe.
//
// Usage
//   Input channel: one pixel word (row, column, old colour) is taken at each
//   edge where i_valid is high and o_stall is low.
//   Output channel: one word (new colour, on_ring flag) leaves at each edge
//   where o_valid is high and i_stall is low.
//   APB port: writes the centre, box sizes, half width and ring colour; pready
//   is tied high. Write only while no pixel is in flight.
// Timing
//   A pixel passes from acceptance to o_valid through the eight-stage test
//   pipeline (offsets, squares, axis scaling, sum, distance, d^2 partial
//   products, d^2 sum, compare). Throughput is one pixel per clock while
//   o_stall is low. Configuration-derived bounds settle after a write, each one
//   before the stage that reads it, so a pixel may follow the write at once.
// Reset and stall
//   Reset empties the pipeline and restores register defaults (half width 6,
//   all else zero, so nothing is marked). When the receiver stalls a valid
//   output, hold every stage and raise o_stall; nothing is dropped or repeated.
`default_nettype none
module ellipse_ring_pixel_marker_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [erpm_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [erpm_pkg::DATA_W-1:0]   pwdata,
    output logic      [erpm_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [erpm_pkg::COORD_W-1:0]  i_pixel_row,
    input  wire logic [erpm_pkg::COORD_W-1:0]  i_pixel_col,
    input  wire logic [erpm_pkg::PIX_W-1:0]    i_old_pixel,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [erpm_pkg::PIX_W-1:0]    o_new_pixel,
    output logic                               o_on_ring
);
    import erpm_pkg::*;

    t_cfg     w_cfg;
    t_derived w_der;

    // register file
    erpm_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // squared bounds from the configuration
    erpm_cfg_derive u_derive (
        .i_clk (i_clk),
        .i_cfg (w_cfg),
        .o_der (w_der)
    );

    // per-pixel test pipeline
    erpm_ring_pipe u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_der       (w_der),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel_row (i_pixel_row),
        .i_pixel_col (i_pixel_col),
        .i_old_pixel (i_old_pixel),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_new_pixel (o_new_pixel),
        .o_on_ring   (o_on_ring)
    );

endmodule
`default_nettype wire

>>> design/erpm_checker.sv
// erpm_checker: port-level assertions for the ellipse ring marker, bound to the
// top level. Depends on ellipse_ring_pixel_marker_core's ports.
`default_nettype none
module erpm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [23:0] o_new_pixel,
    input wire logic        o_on_ring
);

    // Output word holds while the receiver stalls.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_new_pixel) && $stable(o_on_ring)))
        else $error("output word changed under stall");

    // Input stall only comes from a blocked output.
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked output");

    // Pipeline is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind ellipse_ring_pixel_marker_core erpm_checker u_erpm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_new_pixel (o_new_pixel),
    .o_on_ring   (o_on_ring)
);
`default_nettype wire

>>> tb/sv/tb_top.sv
// tb_top: self-checking testbench for ellipse_ring_pixel_marker_core.
// Depends on erpm_pkg and the core RTL; holds its own exact ring predictor.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import erpm_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel, penable, pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 i_valid;
    logic                 o_stall;
    logic [COORD_W-1:0]   i_pixel_row;
    logic [COORD_W-1:0]   i_pixel_col;
    logic [PIX_W-1:0]     i_old_pixel;
    logic                 o_valid;
    logic                 i_stall;
    logic [PIX_W-1:0]     o_new_pixel;
    logic                 o_on_ring;

    ellipse_ring_pixel_marker_core uut (.*);

    // Shadow copy of the registers, updated on each write.
    logic [Q_W-1:0]   cfg_ccol, cfg_crow, cfg_w, cfg_h;
    logic [HW_W-1:0]  cfg_hw;
    logic [PIX_W-1:0] cfg_colour;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             ring;
    } t_marked;

    t_marked expected_pixels[$];
    int      mismatches;
    int      send_idle_pct, stall_pct;
    longint  cycle_count;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Exact ring test on squared bounds; widths chosen so nothing overflows.
    function automatic logic ring_hit(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
        logic [16:0]  px, py, ax, ay;
        logic [33:0]  ax2, ay2;
        logic [31:0]  w2, h2, p;
        logic [63:0]  p2;
        logic [51:0]  t2;
        logic [64:0]  u;
        logic [66:0]  s;
        logic [117:0] k;
        logic [66:0]  d;
        logic [133:0] dsq;
        if (cfg_w == 0 || cfg_h == 0 || cfg_hw == 0) return 1'b0;
        px = {col, 4'b0};
        py = {row, 4'b0};
        ax = (px >= cfg_ccol) ? px - cfg_ccol : cfg_ccol - px;
        ay = (py >= cfg_crow) ? py - cfg_crow : cfg_crow - py;
        ax2 = ax * ax;
        ay2 = ay * ay;
        w2 = cfg_w * cfg_w;
        h2 = cfg_h * cfg_h;
        p = cfg_w * cfg_h;
        p2 = p * p;
        t2 = (52'(cfg_hw) * cfg_hw * 256) * p;
        u = 65'(p2) + t2;
        s = (67'(ax2) * h2 + 67'(ay2) * w2) * 4;
        k = 118'(p2) * t2 * 4;
        if (s < u && p2 < t2) return 1'b1;
        d = (s >= u) ? s - u : u - s;
        dsq = 134'(d) * d;
        return dsq < k;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH %s at cycle %0d", what, cycle_count);
        mismatches++;
    endtask

    // Write one register through the APB port: setup, then access.
    task automatic write_reg(t_reg_idx idx, logic [DATA_W-1:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * int'(idx)); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_CENTRE_COL:  cfg_ccol = val[Q_W-1:0];
            REG_CENTRE_ROW:  cfg_crow = val[Q_W-1:0];
            REG_BOX_WIDTH:   cfg_w = val[Q_W-1:0];
            REG_BOX_HEIGHT:  cfg_h = val[Q_W-1:0];
            REG_HALF_WIDTH:  cfg_hw = val[HW_W-1:0];
            REG_RING_COLOUR: cfg_colour = val[PIX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_ellipse(logic [15:0] cc, logic [15:0] cr, logic [15:0] w,
                               logic [15:0] h, logic [5:0] hw, logic [23:0] colour);
        write_reg(REG_CENTRE_COL, 32'(cc));
        write_reg(REG_CENTRE_ROW, 32'(cr));
        write_reg(REG_BOX_WIDTH, 32'(w));
        write_reg(REG_BOX_HEIGHT, 32'(h));
        write_reg(REG_HALF_WIDTH, 32'(hw));
        write_reg(REG_RING_COLOUR, 32'(colour));
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        // let derived bounds settle
        repeat (6) @(posedge i_clk);
    endtask

    // Send one pixel word; hold it until accepted, predict on acceptance.
    task automatic send_pixel(logic [11:0] row, logic [11:0] col, logic [23:0] old);
        t_marked m;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_row <= row; i_pixel_col <= col; i_old_pixel <= old;
        do @(posedge i_clk); while (o_stall);
        m.ring = ring_hit(row, col);
        m.pix = m.ring ? cfg_colour : old;
        expected_pixels.push_back(m);
    endtask

    // Drain: wait for every expectation, then the pipeline latency.
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // Result checker and receiver stall generator.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            if (o_valid && !i_stall) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected pixel");
                end else begin
                    t_marked e;
                    e = expected_pixels.pop_front();
                    if (o_new_pixel !== e.pix) report_mismatch("new_pixel");
                    if (o_on_ring !== e.ring) report_mismatch("on_ring");
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > 2000000) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Pixels near the current ellipse outline, to hit the ring often.
    task automatic send_near_ring();
        int ang, cx, cy, r, c;
        ang = $urandom_range(359);
        cx = cfg_ccol / 16; cy = cfg_crow / 16;
        c = cx + $rtoi($cos(ang * 3.14159 / 180.0) * cfg_w / 32.0)
            + int'($urandom_range(4)) - 2;
        r = cy + $rtoi($sin(ang * 3.14159 / 180.0) * cfg_h / 32.0)
            + int'($urandom_range(4)) - 2;
        send_pixel(12'(r), 12'(c), 24'($urandom));
    endtask

    task automatic test_reset_defaults();
        cfg_ccol = 0; cfg_crow = 0; cfg_w = 0; cfg_h = 0; cfg_hw = 6; cfg_colour = 0;
        send_pixel(12'd0, 12'd0, 24'h123456);
        send_pixel(12'hFFF, 12'hFFF, 24'hFFFFFF);
        drain();
    endtask

    task automatic test_directed();
        set_ellipse(16'd1600, 16'd1600, 16'd640, 16'd320, 6'd6, 24'hFF0000);
        send_pixel(12'd100, 12'd120, 24'h000000);   // right edge
        send_pixel(12'd110, 12'd100, 24'hFFFFFF);   // bottom edge
        send_pixel(12'd100, 12'd100, 24'hABCDEF);   // centre
        send_pixel(12'd0, 12'd0, 24'h0F0F0F);
        send_pixel(12'hFFF, 12'hFFF, 24'hF0F0F0);
        send_pixel(12'd100, 12'd80, 24'h555555);   // left edge
        drain();
        set_ellipse(16'd1600, 16'd1600, 16'd0, 16'd320, 6'd6, 24'h00FF00); // zero width
        send_pixel(12'd100, 12'd120, 24'h111111);
        drain();
        set_ellipse(16'd1600, 16'd1600, 16'd640, 16'd0, 6'd6, 24'h00FF00); // zero height
        send_pixel(12'd90, 12'd100, 24'h222222);
        drain();
        set_ellipse(16'd1600, 16'd1600, 16'd640, 16'd320, 6'd0, 24'h0000FF); // zero half
        send_pixel(12'd100, 12'd120, 24'h333333);
        drain();
        set_ellipse(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63, 24'hFFFFFF);
        send_pixel(12'hFFF, 12'hFFF, 24'h000000);
        send_pixel(12'd0, 12'd0, 24'h000000);
        send_pixel(12'd0, 12'hFFF, 24'h000000);
        send_near_ring();
        send_near_ring();
        drain();
        set_ellipse(16'd0, 16'd0, 16'd16, 16'd16, 6'd1, 24'h000000);  // tiny, at origin
        send_pixel(12'd0, 12'd0, 24'hFFFFFF);
        send_pixel(12'd0, 12'd1, 24'hFFFFFF);
        send_pixel(12'd1, 12'd0, 24'hFFFFFF);
        drain();
    endtask

    task automatic random_phase(int idle_pct, int stl_pct, int n);
        send_idle_pct = idle_pct;
        stall_pct = stl_pct;
        set_ellipse(16'($urandom), 16'($urandom),
                    ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4000, 16)),
                    ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4000, 16)),
                    6'($urandom_range(63, 1)), 24'($urandom));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 70) send_near_ring();
            else send_pixel(12'($urandom), 12'($urandom), 24'($urandom));
        end
        drain();
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: random_phase(0, 0, 120);
                1: random_phase(54, 0, 120);
                2: random_phase(0, 54, 120);
                default: random_phase(31, 31, 120);
            endcase
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_valid = 1'b0; i_stall = 1'b0;
        i_pixel_row = '0; i_pixel_col = '0; i_old_pixel = '0;
        mismatches = 0; cycle_count = 0;
        send_idle_pct = 0; stall_pct = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed();
        test_random();
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
